// ===== design/terrain_window_metrics_core_macros.svh =====
// ---------------------------------------------------------------------------
// Terrain window metrics: assertion macros
// Shared concurrent assertion wrappers. They compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef TERRAIN_WINDOW_METRICS_CORE_MACROS_SVH
`define TERRAIN_WINDOW_METRICS_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define TWM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define TWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define TWM_ASSERT_SAME(label, clk, rst, ante, cons)
`define TWM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/twm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Terrain window metrics package
// Types, constants and small tables shared by the terrain metrics core.
// ---------------------------------------------------------------------------
package twm_pkg;

   localparam int MAX_COLS     = 4096;
   localparam int COL_W        = $clog2(MAX_COLS);
   localparam int LEN_W        = 13;
   localparam int CORDIC_STEPS = 16;
   localparam int IT_W         = $clog2(CORDIC_STEPS);
   localparam int ZW           = 36;
   localparam int CELL_W       = 33;

   typedef struct packed {
      logic              nd;
      logic signed [31:0] bits;
   } cell_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_METRIC    = 3'd0;
   localparam logic [2:0] CSR_UNIT      = 3'd1;
   localparam logic [2:0] CSR_ROW_LEN   = 3'd2;
   localparam logic [2:0] CSR_INV_X     = 3'd3;
   localparam logic [2:0] CSR_INV_Y     = 3'd4;
   localparam logic [2:0] CSR_INV_DIAG  = 3'd5;

   // Metric selections.
   localparam logic [2:0] MET_TRI     = 3'd0;
   localparam logic [2:0] MET_TPI     = 3'd1;
   localparam logic [2:0] MET_ROUGH   = 3'd2;
   localparam logic [2:0] MET_SLOPE4  = 3'd3;
   localparam logic [2:0] MET_ASPECT4 = 3'd4;
   localparam logic [2:0] MET_SLOPE8  = 3'd5;
   localparam logic [2:0] MET_ASPECT8 = 3'd6;
   localparam logic [2:0] MET_FLOW    = 3'd7;

   // Angle units.
   localparam logic [1:0] UNIT_DEG = 2'd0;
   localparam logic [1:0] UNIT_TAN = 2'd2;

   // Spacing selection for flow neighbours.
   localparam logic [1:0] SP_X = 2'd0;
   localparam logic [1:0] SP_Y = 2'd1;
   localparam logic [1:0] SP_D = 2'd2;

   // Arctangent of 2^-i in Q2.30 radians.
   function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] i);
      logic signed [ZW-1:0] r;
      r = '0;
      case (i)
         5'd0:    r = 36'sh03243F6A8;
         5'd1:    r = 36'sh01DAC6705;
         5'd2:    r = 36'sh00FADBAFC;
         5'd3:    r = 36'sh007F56EA6;
         5'd4:    r = 36'sh003FEAB76;
         5'd5:    r = 36'sh001FFD55B;
         5'd6:    r = 36'sh000FFFAAA;
         5'd7:    r = 36'sh0007FFF55;
         5'd8:    r = 36'sh0003FFFEA;
         5'd9:    r = 36'sh0001FFFFD;
         default: begin
            if (i >= 5'd30) begin
               r = '0;
            end else begin
               r = ZW'((36'sd1 <<< (5'd30 - i)) - 36'sd1);
            end
         end
      endcase
      return r;
   endfunction

   // Window slot of flow neighbour j, order E, SE, S, SW, W, NW, N, NE.
   function automatic logic [3:0] fl_pos(input logic [2:0] j);
      logic [3:0] r;
      case (j)
         3'd0:    r = 4'd5;
         3'd1:    r = 4'd8;
         3'd2:    r = 4'd7;
         3'd3:    r = 4'd6;
         3'd4:    r = 4'd3;
         3'd5:    r = 4'd0;
         3'd6:    r = 4'd1;
         default: r = 4'd2;
      endcase
      return r;
   endfunction

   // Spacing of flow neighbour j: diagonals on odd j, x on E and W.
   function automatic logic [1:0] fl_sp(input logic [2:0] j);
      logic [1:0] r;
      if (j[0]) begin
         r = SP_D;
      end else if (j[1]) begin
         r = SP_Y;
      end else begin
         r = SP_X;
      end
      return r;
   endfunction

endpackage

// ===== design/terrain_window_metrics_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Terrain window metrics core
// 3x3 terrain metrics (TRI, TPI, roughness, slope, aspect, D8 flow) over a
// streamed elevation grid, with line buffers in one synchronous memory.
// ---------------------------------------------------------------------------
// Usage:
// Elevation cells enter on the req_ channel in row order, one transaction per
// cell. Once a full row and one more cell have arrived, every cell produces
// one result transaction on the rsp_ channel for the cell one row and one
// column behind it; a cell before that point produces none.
// One cell is processed at a time. Each cell passes a line buffer
// read-modify-write (read on accept, write back in ST_READ) and then the
// metric sequence. Slope and aspect first halve a gradient that is too large,
// and a slope angle takes a second CORDIC pass. A CORDIC pass on a zero vector
// skips its 16 micro-rotations; the iterative CORDIC does one micro-rotation
// per cycle. An edge cell goes straight from the read-modify-write to the
// output register with an invalid result.
// A finished result sits in an output register, so the next cell is taken
// while the receiver stalls; the core only waits if a second result is ready
// before the first is taken.
// Reset (synchronous, active high) clears the configuration to its defaults,
// the column and row counters and the window. The line buffer memory is not
// cleared; entries are always written before they feed a valid result.
// Configuration writes on the csr_ port take effect at once and are meant to
// be made only while the core is idle.
// ---------------------------------------------------------------------------
`include "terrain_window_metrics_core_macros.svh"

module terrain_window_metrics_core
   import twm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // Cell input: tdata = elevation[31:0]; tuser = no_data[0].
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic signed [31:0] req_tdata,
   input  logic [0:0]         req_tuser,
   // Result output: tdata = value[39:0]; tuser = invalid[0].
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic signed [39:0] rsp_tdata,
   output logic [0:0]         rsp_tuser,
   // Configuration write port.
   input  logic               csr_we,
   input  logic [2:0]         csr_addr,
   input  logic [31:0]        csr_wdata
);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_READ = 4'd1;
   localparam logic [3:0] ST_EVAL = 4'd2;
   localparam logic [3:0] ST_STAT = 4'd3;
   localparam logic [3:0] ST_SFIN = 4'd4;
   localparam logic [3:0] ST_GMUL = 4'd5;
   localparam logic [3:0] ST_RED  = 4'd6;
   localparam logic [3:0] ST_CPRE = 4'd7;
   localparam logic [3:0] ST_CIT  = 4'd8;
   localparam logic [3:0] ST_CMAG = 4'd9;
   localparam logic [3:0] ST_CSAT = 4'd10;
   localparam logic [3:0] ST_UMUL = 4'd11;
   localparam logic [3:0] ST_UFIN = 4'd12;
   localparam logic [3:0] ST_FMUL = 4'd13;
   localparam logic [3:0] ST_FCMP = 4'd14;
   localparam logic [3:0] ST_OUT  = 4'd15;

   localparam int GM_W = 35;          // gradient sum magnitude
   localparam int GP_W = GM_W + 16;   // partial product of the gradient scale
   localparam int GW   = 54;          // scaled gradient
   localparam int CW   = 44;          // CORDIC x and y
   localparam int MP_W = CW - 1 + 16; // magnitude gain product
   localparam int UP_W = ZW + 23;     // unit conversion product
   localparam int FP_W = 65;          // flow drop product

   localparam logic signed [GW-1:0] GRAD_LIM     = 54'sd1099511627776;
   localparam logic signed [ZW-1:0] HALF_PI_Q30  = 36'sd1686629713;
   localparam logic signed [ZW-1:0] TWO_PI_Q30   = 36'sd6746518852;
   localparam logic signed [39:0]   TWO_PI_Q16   = 40'sd411775;
   localparam logic signed [39:0]   TURN_DEG_Q16 = 40'sd23592960;
   localparam logic [39:0]          OUT_MAX      = {1'b0, {39{1'b1}}};
   localparam logic [15:0]          INV_GAIN_Q16 = 16'd39797;
   localparam logic signed [22:0]   RAD2DEG_Q16  = 23'sd3754936;
   localparam logic signed [CW-1:0] ONE_Q16      = 44'sd65536;

   // Configuration.
   logic [2:0]  metric_ff, metric_in;
   logic [1:0]  unit_ff, unit_in;
   logic [LEN_W-1:0] row_len_ff, row_len_in;
   logic [31:0] inv_x_ff, inv_x_in, inv_y_ff, inv_y_in, inv_d_ff, inv_d_in;

   // Stream position and sequencer.
   logic [3:0]       state_ff, state_in;
   logic [COL_W-1:0] column_ff, column_in, cur_col_ff, cur_col_in;
   logic [1:0]       rows_ff, rows_in;
   logic             emit_ff, emit_in, edge_ff, edge_in;
   cell_type         nc_ff, nc_in;
   cell_type         win_ff [9];
   cell_type         win_in [9];

   // Line buffer memory: upper half is the older row, lower half the newer.
   logic [2*CELL_W-1:0] lb_mem [MAX_COLS];
   logic [2*CELL_W-1:0] lb_rdata_ff;
   logic                lb_rd_en, lb_we;
   logic [2*CELL_W-1:0] lb_wdata;

   // Statistics loop.
   logic [3:0]         idx_ff, idx_in;
   logic signed [37:0] acc_ff, acc_in;
   logic signed [31:0] mx_ff, mx_in, mn_ff, mn_in;

   // Gradient scaling.
   logic [2:0]         gph_ff, gph_in;
   logic               horn_ff, horn_in;
   logic [GM_W-1:0]    gmx_ff, gmx_in, gmy_ff, gmy_in;
   logic               gnx_ff, gnx_in, gny_ff, gny_in;
   logic [GP_W-1:0]    gprod_ff, gprod_in, ghi_ff, ghi_in;
   logic signed [GW-1:0] zx_ff, zx_in, zy_ff, zy_in;
   logic               shifted_ff, shifted_in;

   // CORDIC and angle conversion.
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in, ang_ff, ang_in;
   logic [IT_W-1:0]      it_ff, it_in;
   logic                 pass2_ff, pass2_in;
   logic [MP_W-1:0]      mprod_ff, mprod_in;
   logic signed [UP_W-1:0] uprod_ff, uprod_in;

   // Flow direction search.
   logic [FP_W-1:0] fprod_ff, fprod_in, bmag_ff, bmag_in;
   logic            fneg_ff, fneg_in, fnd_ff, fnd_in;
   logic            found_ff, found_in, bneg_ff, bneg_in;
   logic [2:0]      best_ff, best_in;

   // Result and output register.
   logic signed [39:0] res_val_ff, res_val_in, rsp_value_ff, rsp_value_in;
   logic               res_bad_ff, res_bad_in, rsp_invalid_ff, rsp_invalid_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic [LEN_W-1:0] len_eff;
   logic [3:0]       sel_idx;
   cell_type         win_sel;

   function automatic logic signed [35:0] ext36(input cell_type c);
      return {{4{c.bits[31]}}, c.bits};
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_invalid_ff;

   assign len_eff = (row_len_ff < LEN_W'(3)) ? LEN_W'(3) :
                    (row_len_ff > LEN_W'(MAX_COLS)) ? LEN_W'(MAX_COLS) : row_len_ff;

   // Single window read port shared by the statistics and flow loops.
   assign sel_idx = (state_ff == ST_FMUL) ? fl_pos(idx_ff[2:0]) : idx_ff;
   assign win_sel = win_ff[sel_idx];

   assign lb_rd_en = accept;
   assign lb_we    = (state_ff == ST_READ);
   assign lb_wdata = {lb_rdata_ff[CELL_W-1:0], nc_ff};

   always_comb begin
      logic [LEN_W-1:0]   col_next;
      cell_type           top_c, mid_c;
      logic               any_nd, nb_nd;
      logic signed [35:0] e_nw, e_n, e_ne, e_w, e_c, e_e, e_sw, e_s, e_se;
      logic signed [35:0] sx, sy;
      logic signed [33:0] d34;
      logic [32:0]        ad33;
      logic signed [31:0] es;
      logic [GM_W-1:0]    gop;
      logic [31:0]        ginv;
      logic [15:0]        ghalf;
      logic [GP_W:0]      gp;
      logic signed [GW-1:0] gz;
      logic signed [CW-1:0] dx, dy;
      logic signed [ZW-1:0] aa;
      logic [CW-2:0]      mfull;
      logic [39:0]        m40;
      logic signed [39:0] v;
      logic signed [UP_W-1:0] ur;
      logic signed [ZW-1:0] rr;
      logic [31:0]        finv;
      logic               neg, better, f_found;
      logic [2:0]         f_best;
      logic               is_aspect;

      metric_in = metric_ff;   unit_in = unit_ff;   row_len_in = row_len_ff;
      inv_x_in = inv_x_ff;     inv_y_in = inv_y_ff; inv_d_in = inv_d_ff;
      state_in = state_ff;     column_in = column_ff; cur_col_in = cur_col_ff;
      rows_in = rows_ff;       emit_in = emit_ff;   edge_in = edge_ff;
      nc_in = nc_ff;
      for (int i = 0; i < 9; i++) begin
         win_in[i] = win_ff[i];
      end
      idx_in = idx_ff;   acc_in = acc_ff;   mx_in = mx_ff;   mn_in = mn_ff;
      gph_in = gph_ff;   horn_in = horn_ff; gmx_in = gmx_ff; gmy_in = gmy_ff;
      gnx_in = gnx_ff;   gny_in = gny_ff;   gprod_in = gprod_ff; ghi_in = ghi_ff;
      zx_in = zx_ff;     zy_in = zy_ff;     shifted_in = shifted_ff;
      x_in = x_ff;       y_in = y_ff;       z_in = z_ff;     ang_in = ang_ff;
      it_in = it_ff;     pass2_in = pass2_ff;
      mprod_in = mprod_ff; uprod_in = uprod_ff;
      fprod_in = fprod_ff; bmag_in = bmag_ff; fneg_in = fneg_ff; fnd_in = fnd_ff;
      found_in = found_ff; bneg_in = bneg_ff; best_in = best_ff;
      res_val_in = res_val_ff; res_bad_in = res_bad_ff;
      rsp_value_in = rsp_value_ff; rsp_invalid_in = rsp_invalid_ff;
      rsp_valid_in = rsp_valid_ff;

      top_c = cell_type'(lb_rdata_ff[2*CELL_W-1:CELL_W]);
      mid_c = cell_type'(lb_rdata_ff[CELL_W-1:0]);
      col_next = {1'b0, column_ff} + LEN_W'(1);

      any_nd = 1'b0;
      nb_nd  = 1'b0;
      for (int i = 0; i < 9; i++) begin
         if (win_ff[i].nd) begin
            any_nd = 1'b1;
            if (i != 4) begin
               nb_nd = 1'b1;
            end
         end
      end
      e_nw = ext36(win_ff[0]); e_n = ext36(win_ff[1]); e_ne = ext36(win_ff[2]);
      e_w  = ext36(win_ff[3]); e_c = ext36(win_ff[4]); e_e  = ext36(win_ff[5]);
      e_sw = ext36(win_ff[6]); e_s = ext36(win_ff[7]); e_se = ext36(win_ff[8]);
      if (metric_ff == MET_SLOPE8 || metric_ff == MET_ASPECT8) begin
         sx = (e_nw + (e_w <<< 1) + e_sw) - (e_ne + (e_e <<< 1) + e_se);
         sy = (e_sw + (e_s <<< 1) + e_se) - (e_nw + (e_n <<< 1) + e_ne);
      end else begin
         sx = e_w - e_e;
         sy = e_s - e_n;
      end

      es   = win_sel.bits;
      d34  = (state_ff == ST_FMUL) ? (34'(e_c) - 34'(ext36(win_sel)))
                                   : (34'(ext36(win_sel)) - 34'(e_c));
      ad33 = d34[33] ? 33'(-d34) : 33'(d34);

      gop   = (gph_ff < 3'd3) ? gmx_ff : gmy_ff;
      ginv  = (gph_ff < 3'd3) ? inv_x_ff : inv_y_ff;
      ghalf = (gph_ff == 3'd0 || gph_ff == 3'd3) ? ginv[31:16] : ginv[15:0];
      gp    = ({1'b0, ghi_ff} + (GP_W + 1)'(gprod_ff >> 16)) >> (horn_ff ? 3 : 1);
      gz    = GW'($signed({1'b0, gp}));

      dx = x_ff >>> it_ff;
      dy = y_ff >>> it_ff;

      is_aspect = (metric_ff == MET_ASPECT4 || metric_ff == MET_ASPECT8);
      aa = HALF_PI_Q30 - z_ff;
      if (aa < 0) begin
         aa = aa + TWO_PI_Q30;
      end else if (aa >= TWO_PI_Q30) begin
         aa = aa - TWO_PI_Q30;
      end

      mfull = mprod_ff[MP_W-1:16];
      m40 = (shifted_ff || mfull > (CW - 1)'(OUT_MAX)) ? OUT_MAX : mfull[39:0];

      ur = (uprod_ff + UP_W'(64'sd536870912)) >>> 30;
      rr = (ang_ff + ZW'(8192)) >>> 14;
      v  = (unit_ff == UNIT_DEG) ? 40'(ur) : 40'(rr);
      if (is_aspect) begin
         if (unit_ff == UNIT_DEG) begin
            if (v >= TURN_DEG_Q16) begin
               v = v - TURN_DEG_Q16;
            end
         end else if (v >= TWO_PI_Q16) begin
            v = v - TWO_PI_Q16;
         end
      end

      case (fl_sp(idx_ff[2:0]))
         SP_X:    finv = inv_x_ff;
         SP_Y:    finv = inv_y_ff;
         default: finv = inv_d_ff;
      endcase
      neg = fneg_ff && (fprod_ff != '0);
      if (!found_ff) begin
         better = 1'b1;
      end else if (neg != bneg_ff) begin
         better = !neg;
      end else begin
         better = neg ? (fprod_ff < bmag_ff) : (fprod_ff > bmag_ff);
      end
      better  = better && !fnd_ff;
      f_found = found_ff || better;
      f_best  = better ? idx_ff[2:0] : best_ff;

      // Configuration writes.
      if (csr_we) begin
         case (csr_addr)
            CSR_METRIC:   metric_in  = csr_wdata[2:0];
            CSR_UNIT:     unit_in    = csr_wdata[1:0];
            CSR_ROW_LEN:  row_len_in = csr_wdata[LEN_W-1:0];
            CSR_INV_X:    inv_x_in   = csr_wdata;
            CSR_INV_Y:    inv_y_in   = csr_wdata;
            CSR_INV_DIAG: inv_d_in   = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               nc_in      = '{nd: req_tuser[0], bits: req_tdata};
               cur_col_in = column_ff;
               emit_in    = (rows_ff >= 2'd2) || (rows_ff == 2'd1 && column_ff != '0);
               edge_in    = (column_ff <= COL_W'(1)) || (rows_ff == 2'd1);
               if (col_next >= len_eff) begin
                  column_in = '0;
                  if (rows_ff != 2'd3) begin
                     rows_in = rows_ff + 2'd1;
                  end
               end else begin
                  column_in = col_next[COL_W-1:0];
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            for (int r = 0; r < 3; r++) begin
               win_in[r*3]     = win_ff[r*3 + 1];
               win_in[r*3 + 1] = win_ff[r*3 + 2];
            end
            win_in[2] = top_c;
            win_in[5] = mid_c;
            win_in[8] = nc_ff;
            if (!emit_ff) begin
               state_in = ST_IDLE;
            end else if (edge_ff) begin
               res_val_in = '0;
               res_bad_in = 1'b1;
               state_in   = ST_OUT;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            res_val_in = '0;
            res_bad_in = 1'b1;
            state_in   = ST_OUT;
            case (metric_ff)
               MET_TRI, MET_TPI, MET_ROUGH: begin
                  if (!any_nd) begin
                     acc_in   = '0;
                     mx_in    = win_ff[4].bits;
                     mn_in    = win_ff[4].bits;
                     idx_in   = '0;
                     state_in = ST_STAT;
                  end
               end
               MET_FLOW: begin
                  if (!win_ff[4].nd) begin
                     idx_in   = '0;
                     found_in = 1'b0;
                     state_in = ST_FMUL;
                  end
               end
               default: begin
                  // Slope and aspect: 4-neighbour needs N, S, W, E; Horn all eight.
                  horn_in = (metric_ff == MET_SLOPE8 || metric_ff == MET_ASPECT8);
                  if (horn_in ? !nb_nd
                              : !(win_ff[1].nd || win_ff[7].nd || win_ff[3].nd ||
                                  win_ff[5].nd)) begin
                     gnx_in     = sx[35];
                     gny_in     = sy[35];
                     gmx_in     = sx[35] ? GM_W'(-sx) : GM_W'(sx);
                     gmy_in     = sy[35] ? GM_W'(-sy) : GM_W'(sy);
                     gph_in     = '0;
                     shifted_in = 1'b0;
                     pass2_in   = 1'b0;
                     state_in   = ST_GMUL;
                  end
               end
            endcase
         end
         ST_STAT: begin
            if (metric_ff == MET_TRI) begin
               acc_in = acc_ff + 38'(ad33);
            end else if (metric_ff == MET_TPI && idx_ff != 4'd4) begin
               acc_in = acc_ff + 38'(es);
            end
            if (es > mx_ff) begin
               mx_in = es;
            end
            if (es < mn_ff) begin
               mn_in = es;
            end
            if (idx_ff == 4'd8) begin
               state_in = ST_SFIN;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
         ST_SFIN: begin
            case (metric_ff)
               MET_TRI: res_val_in = 40'(acc_ff >>> 3);
               MET_TPI: res_val_in = 40'(e_c) - 40'(acc_ff >>> 3);
               default: res_val_in = 40'(mx_ff) - 40'(mn_ff);
            endcase
            res_bad_in = 1'b0;
            state_in   = ST_OUT;
         end
         ST_GMUL: begin
            gprod_in = gop * ghalf;
            if (gph_ff == 3'd1 || gph_ff == 3'd4) begin
               ghi_in = gprod_ff;
            end
            if (gph_ff == 3'd2) begin
               zx_in = gnx_ff ? -gz : gz;
            end
            if (gph_ff == 3'd5) begin
               zy_in    = gny_ff ? -gz : gz;
               state_in = ST_RED;
            end else begin
               gph_in = gph_ff + 3'd1;
            end
         end
         ST_RED: begin
            // Halve both components together until each is below 2^40.
            if (zx_ff >= GRAD_LIM || zx_ff <= -GRAD_LIM ||
                zy_ff >= GRAD_LIM || zy_ff <= -GRAD_LIM) begin
               zx_in      = zx_ff >>> 1;
               zy_in      = zy_ff >>> 1;
               shifted_in = 1'b1;
            end else begin
               x_in     = zx_ff[CW-1:0];
               y_in     = zy_ff[CW-1:0];
               state_in = ST_CPRE;
            end
         end
         ST_CPRE: begin
            it_in = '0;
            z_in  = '0;
            if (x_ff < 0) begin
               if (y_ff >= 0) begin
                  x_in = y_ff;
                  y_in = -x_ff;
                  z_in = HALF_PI_Q30;
               end else begin
                  x_in = -y_ff;
                  y_in = x_ff;
                  z_in = -HALF_PI_Q30;
               end
            end
            // A zero vector keeps magnitude and angle at zero.
            state_in = (x_ff == '0 && y_ff == '0) ? ST_CMAG : ST_CIT;
         end
         ST_CIT: begin
            if (y_ff >= 0) begin
               x_in = x_ff + dy;
               y_in = y_ff - dx;
               z_in = z_ff + atan_step(5'(it_ff));
            end else begin
               x_in = x_ff - dy;
               y_in = y_ff + dx;
               z_in = z_ff - atan_step(5'(it_ff));
            end
            if (it_ff == IT_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_CMAG;
            end else begin
               it_in = it_ff + IT_W'(1);
            end
         end
         ST_CMAG: begin
            if (is_aspect) begin
               ang_in   = aa;
               state_in = ST_UMUL;
            end else if (pass2_ff) begin
               ang_in   = z_ff;
               state_in = ST_UMUL;
            end else begin
               mprod_in = x_ff[CW-2:0] * INV_GAIN_Q16;
               state_in = ST_CSAT;
            end
         end
         ST_CSAT: begin
            if (unit_ff >= UNIT_TAN) begin
               res_val_in = $signed(m40);
               res_bad_in = 1'b0;
               state_in   = ST_OUT;
            end else begin
               // Slope angle: second vectoring pass on (1, tangent).
               x_in     = ONE_Q16;
               y_in     = CW'(m40);
               pass2_in = 1'b1;
               state_in = ST_CPRE;
            end
         end
         ST_UMUL: begin
            uprod_in = ang_ff * RAD2DEG_Q16;
            state_in = ST_UFIN;
         end
         ST_UFIN: begin
            res_val_in = v;
            res_bad_in = 1'b0;
            state_in   = ST_OUT;
         end
         ST_FMUL: begin
            fprod_in = ad33 * finv;
            fneg_in  = d34[33];
            fnd_in   = win_sel.nd;
            state_in = ST_FCMP;
         end
         ST_FCMP: begin
            found_in = f_found;
            best_in  = f_best;
            if (better) begin
               bneg_in = neg;
               bmag_in = fprod_ff;
            end
            if (idx_ff == 4'd7) begin
               res_bad_in = !f_found;
               res_val_in = f_found ? (40'sd1 <<< f_best) : '0;
               state_in   = ST_OUT;
            end else begin
               idx_in   = idx_ff + 4'd1;
               state_in = ST_FMUL;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_value_in   = res_val_ff;
               rsp_invalid_in = res_bad_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         metric_ff    <= MET_TRI;
         unit_ff      <= UNIT_DEG;
         row_len_ff   <= LEN_W'(3);
         inv_x_ff     <= 32'd65536;
         inv_y_ff     <= 32'd65536;
         inv_d_ff     <= 32'd46341;
         column_ff    <= '0;
         rows_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '{nd: 1'b1, bits: '0};
         end
      end else begin
         state_ff     <= state_in;
         metric_ff    <= metric_in;
         unit_ff      <= unit_in;
         row_len_ff   <= row_len_in;
         inv_x_ff     <= inv_x_in;
         inv_y_ff     <= inv_y_in;
         inv_d_ff     <= inv_d_in;
         column_ff    <= column_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cur_col_ff <= cur_col_in;   emit_ff <= emit_in;   edge_ff <= edge_in;
      nc_ff <= nc_in;
      idx_ff <= idx_in;   acc_ff <= acc_in;   mx_ff <= mx_in;   mn_ff <= mn_in;
      gph_ff <= gph_in;   horn_ff <= horn_in; gmx_ff <= gmx_in; gmy_ff <= gmy_in;
      gnx_ff <= gnx_in;   gny_ff <= gny_in;   gprod_ff <= gprod_in; ghi_ff <= ghi_in;
      zx_ff <= zx_in;     zy_ff <= zy_in;     shifted_ff <= shifted_in;
      x_ff <= x_in;       y_ff <= y_in;       z_ff <= z_in;     ang_ff <= ang_in;
      it_ff <= it_in;     pass2_ff <= pass2_in;
      mprod_ff <= mprod_in; uprod_ff <= uprod_in;
      fprod_ff <= fprod_in; bmag_ff <= bmag_in; fneg_ff <= fneg_in; fnd_ff <= fnd_in;
      found_ff <= found_in; bneg_ff <= bneg_in; best_ff <= best_in;
      res_val_ff <= res_val_in; res_bad_ff <= res_bad_in;
      rsp_value_ff <= rsp_value_in; rsp_invalid_ff <= rsp_invalid_in;
   end

   // Line buffer memory: read on accept, write back the shifted column next cycle.
   always_ff @(posedge clock) begin
      if (lb_rd_en) begin
         lb_rdata_ff <= lb_mem[column_ff];
      end
      if (lb_we) begin
         lb_mem[cur_col_ff] <= lb_wdata;
      end
   end

   `TWM_ASSERT_NEXT(a_accept_reads, clock, reset, req_tvalid && req_tready, state_ff == ST_READ)
   `TWM_ASSERT_SAME(a_bad_is_zero, clock, reset, rsp_valid_ff && rsp_invalid_ff, rsp_value_ff == '0)
   `TWM_ASSERT_NEXT(a_rows_hold, clock, reset, rows_ff == 2'd3, rows_ff == 2'd3)
   `TWM_ASSERT_SAME(a_cordic_x_pos, clock, reset, state_ff == ST_CIT, !x_ff[CW-1])

endmodule
